// ===== sv/mbl_pkg.sv =====
// Shared constants and result kinds for the mailbox boot loader.
// No dependencies; used by the top level and its port checker.
package mbl_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned ROT_L  = 3;

  localparam logic [15:0] CMD_MAGIC   = 16'h80F3;
  localparam logic [15:0] REPLY_MAGIC = 16'hFEEE;

  localparam logic [WORD_W-1:0] CMD_SOURCE = 32'h80F3_A001;
  localparam logic [WORD_W-1:0] CMD_LENGTH = 32'h80F3_A002;
  localparam logic [WORD_W-1:0] CMD_DEST   = 32'h80F3_C002;
  localparam logic [WORD_W-1:0] CMD_BOOT   = 32'h80F3_D001;

  localparam logic [KIND_W-1:0] KIND_REPLY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

endpackage

// ===== sv/mailbox_boot_loader_with_checksum_unit.sv =====
// Mailbox boot loader with rotate-xor checksum: command decode and hashing.
// Depends on mbl_pkg for command codes and result kinds.
//
// Accepts one transaction per cycle. Each accepted item is held in the
// input register, is decoded against the loader state and lands in the result
// register. A result therefore appears on the output when its item leaves the
// input register, and the receiver can take it at the next edge at the earliest.
// The result register is the only limit on throughput: while it holds a result
// that the receiver stalls, items that produce a result wait in the input
// register; items that produce none still pass. Mails are rejected with a
// reply, held as commands, or taken as command parameters; the boot command
// issues the first read request (or finishes at once for zero length), and
// every returned byte folds into the checksum and triggers the next request
// or the final boot-done result. Mails during a pass and bytes outside one
// are dropped without a result.
module mailbox_boot_loader_with_checksum_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [mbl_pkg::WORD_W-1:0]    in_mail_word,
  input  logic [mbl_pkg::BYTE_W-1:0]    in_memory_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mbl_pkg::KIND_W-1:0]    out_result_kind,
  output logic [mbl_pkg::WORD_W-1:0]    out_reply_mail,
  output logic [mbl_pkg::WORD_W-1:0]    out_read_address,
  output logic [mbl_pkg::WORD_W-1:0]    out_checksum,
  output logic [mbl_pkg::WORD_W-1:0]    out_dest_address,
  output logic [mbl_pkg::WORD_W-1:0]    out_start_pc
);

  localparam int unsigned W = mbl_pkg::WORD_W;
  localparam int unsigned R = mbl_pkg::ROT_L;

  // loader state
  logic [W-1:0] pend_r,  pend_nxt;
  logic [W-1:0] src_r,   src_nxt;
  logic [W-1:0] len_r,   len_nxt;
  logic [W-1:0] dst_r,   dst_nxt;
  logic [W-1:0] entry_r, entry_nxt;
  logic [W-1:0] sum_r,   sum_nxt;
  logic [W-1:0] idx_r,   idx_nxt;
  logic         hashing_r, hashing_nxt;

  // input register
  logic                      s1_valid_r;
  logic                      s1_op_r;
  logic [W-1:0]              s1_mail_r;
  logic [mbl_pkg::BYTE_W-1:0] s1_byte_r;

  // result register
  logic                       out_valid_r;
  logic [mbl_pkg::KIND_W-1:0] kind_r;
  logic [W-1:0]               reply_r, addr_r, csum_r, dest_r, pc_r;

  // decoded result
  logic                       res_valid;
  logic [mbl_pkg::KIND_W-1:0] res_kind;
  logic [W-1:0]               res_reply, res_addr, res_csum, res_dest, res_pc;

  logic [W-1:0] sum_x, sum_rot, idx_inc;
  logic         out_free, s1_adv;

  assign sum_x   = sum_r ^ {{(W-mbl_pkg::BYTE_W){1'b0}}, s1_byte_r};
  assign sum_rot = {sum_x[W-R-1:0], sum_x[W-1:W-R]};
  assign idx_inc = idx_r + {{(W-1){1'b0}}, 1'b1};

  always_comb begin
    pend_nxt    = pend_r;
    src_nxt     = src_r;
    len_nxt     = len_r;
    dst_nxt     = dst_r;
    entry_nxt   = entry_r;
    sum_nxt     = sum_r;
    idx_nxt     = idx_r;
    hashing_nxt = hashing_r;
    res_valid   = 1'b0;
    res_kind    = mbl_pkg::KIND_REPLY;
    res_reply   = '0;
    res_addr    = '0;
    res_csum    = '0;
    res_dest    = '0;
    res_pc      = '0;
    if (s1_op_r) begin
      if (hashing_r) begin
        sum_nxt   = sum_rot;
        idx_nxt   = idx_inc;
        res_valid = 1'b1;
        if (idx_inc < len_r) begin
          res_kind = mbl_pkg::KIND_READ;
          res_addr = src_r + idx_inc;
        end else begin
          hashing_nxt = 1'b0;
          res_kind    = mbl_pkg::KIND_DONE;
          res_csum    = sum_rot;
          res_dest    = dst_r;
          res_pc      = entry_r;
        end
      end
    end else if (!hashing_r) begin
      if (pend_r == '0) begin
        if (s1_mail_r[W-1:W-16] != mbl_pkg::CMD_MAGIC) begin
          res_valid = 1'b1;
          res_kind  = mbl_pkg::KIND_REPLY;
          res_reply = {mbl_pkg::REPLY_MAGIC, s1_mail_r[15:0]};
        end else begin
          pend_nxt = s1_mail_r;
        end
      end else begin
        pend_nxt = '0;
        case (pend_r)
          mbl_pkg::CMD_SOURCE: src_nxt = s1_mail_r;
          mbl_pkg::CMD_LENGTH: len_nxt = s1_mail_r;
          mbl_pkg::CMD_DEST:   dst_nxt = s1_mail_r;
          mbl_pkg::CMD_BOOT: begin
            entry_nxt = s1_mail_r;
            sum_nxt   = '0;
            idx_nxt   = '0;
            res_valid = 1'b1;
            if (len_r != '0) begin
              hashing_nxt = 1'b1;
              res_kind    = mbl_pkg::KIND_READ;
              res_addr    = src_r;
            end else begin
              res_kind = mbl_pkg::KIND_DONE;
              res_dest = dst_r;
              res_pc   = s1_mail_r;
            end
          end
          default: ; // drop parameter of an unknown command
        endcase
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!res_valid || out_free);
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      src_r       <= '0;
      len_r       <= '0;
      dst_r       <= '0;
      entry_r     <= '0;
      sum_r       <= '0;
      idx_r       <= '0;
      hashing_r   <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        pend_r    <= pend_nxt;
        src_r     <= src_nxt;
        len_r     <= len_nxt;
        dst_r     <= dst_nxt;
        entry_r   <= entry_nxt;
        sum_r     <= sum_nxt;
        idx_r     <= idx_nxt;
        hashing_r <= hashing_nxt;
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r   <= in_operation;
      s1_mail_r <= in_mail_word;
      s1_byte_r <= in_memory_byte;
    end
    if (s1_adv && res_valid) begin
      kind_r  <= res_kind;
      reply_r <= res_reply;
      addr_r  <= res_addr;
      csum_r  <= res_csum;
      dest_r  <= res_dest;
      pc_r    <= res_pc;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_reply_mail   = reply_r;
  assign out_read_address = addr_r;
  assign out_checksum     = csum_r;
  assign out_dest_address = dest_r;
  assign out_start_pc     = pc_r;

endmodule

// ===== sv/mbl_checker.sv =====
// Port-level checker for the mailbox boot loader, bound to the top level.
// Depends on mbl_pkg for result kinds.
module mbl_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [mbl_pkg::KIND_W-1:0] out_result_kind,
  input logic [mbl_pkg::WORD_W-1:0] out_reply_mail,
  input logic [mbl_pkg::WORD_W-1:0] out_read_address,
  input logic [mbl_pkg::WORD_W-1:0] out_checksum,
  input logic [mbl_pkg::WORD_W-1:0] out_dest_address,
  input logic [mbl_pkg::WORD_W-1:0] out_start_pc
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind)
      && $stable(out_reply_mail) && $stable(out_read_address)
      && $stable(out_checksum))
    else $error("stalled result changed");

  // a reply always carries the rejection tag and nothing else
  a_reply_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == mbl_pkg::KIND_REPLY |->
      out_reply_mail[31:16] == mbl_pkg::REPLY_MAGIC && out_read_address == '0
      && out_checksum == '0 && out_start_pc == '0)
    else $error("malformed reply");

  // a read request leaves the boot-done fields clear
  a_read_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == mbl_pkg::KIND_READ |->
      out_reply_mail == '0 && out_checksum == '0 && out_dest_address == '0
      && out_start_pc == '0)
    else $error("malformed read request");

  // an input held off while the result side is free would lose throughput
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result side free");

endmodule

bind mailbox_boot_loader_with_checksum_unit mbl_checker u_mbl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_kind  (out_result_kind),
  .out_reply_mail   (out_reply_mail),
  .out_read_address (out_read_address),
  .out_checksum     (out_checksum),
  .out_dest_address (out_dest_address),
  .out_start_pc     (out_start_pc)
);

// ===== bench/mbl_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the mailbox boot loader: watches both channels, models the loader
// state and compares every accepted result. Depends on mbl_pkg for codes and widths.
module mbl_result_checker
  import mbl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_operation,
  input  logic [WORD_W-1:0] in_mail_word,
  input  logic [BYTE_W-1:0] in_memory_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [KIND_W-1:0] out_result_kind,
  input  logic [WORD_W-1:0] out_reply_mail,
  input  logic [WORD_W-1:0] out_read_address,
  input  logic [WORD_W-1:0] out_checksum,
  input  logic [WORD_W-1:0] out_dest_address,
  input  logic [WORD_W-1:0] out_start_pc,
  output int                open_results,
  output int                fail_count
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] reply;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] dest;
    logic [WORD_W-1:0] pc;
  } loader_result_t;

  localparam logic OP_BYTE = 1'b1;

  loader_result_t loader_results[$];

  logic [WORD_W-1:0] cmd_held;
  logic [WORD_W-1:0] src_base;
  logic [WORD_W-1:0] load_len;
  logic [WORD_W-1:0] dest_word;
  logic [WORD_W-1:0] entry_pc;
  logic [WORD_W-1:0] rot_sum;
  logic [WORD_W-1:0] fetch_idx;
  logic              in_pass;
  int                mismatches = 0;

  // Next byte request, or close the pass with the boot-done result.
  task automatic fetch_or_finish(output loader_result_t r);
    r = '0;
    if (fetch_idx < load_len) begin
      r.kind = KIND_READ;
      r.addr = src_base + fetch_idx;
    end else begin
      in_pass = 1'b0;
      r.kind  = KIND_DONE;
      r.sum   = rot_sum;
      r.dest  = dest_word;
      r.pc    = entry_pc;
    end
  endtask

  task automatic loader_step(input logic op, input logic [WORD_W-1:0] mail,
                             input logic [BYTE_W-1:0] mem_byte);
    loader_result_t r;
    logic           emit;
    r    = '0;
    emit = 1'b0;
    if (op == OP_BYTE) begin
      if (in_pass) begin
        rot_sum   = rot_sum ^ {{(WORD_W-BYTE_W){1'b0}}, mem_byte};
        rot_sum   = (rot_sum << ROT_L) | (rot_sum >> (WORD_W - ROT_L));
        fetch_idx = fetch_idx + 1;
        fetch_or_finish(r);
        emit = 1'b1;
      end
    end else if (!in_pass) begin
      if (cmd_held == '0) begin
        if (mail[31:16] != CMD_MAGIC) begin
          r.kind  = KIND_REPLY;
          r.reply = {REPLY_MAGIC, mail[15:0]};
          emit    = 1'b1;
        end else begin
          cmd_held = mail;
        end
      end else begin
        case (cmd_held)
          CMD_SOURCE: src_base  = mail;
          CMD_LENGTH: load_len  = mail;
          CMD_DEST:   dest_word = mail;
          CMD_BOOT: begin
            entry_pc  = mail;
            rot_sum   = '0;
            fetch_idx = '0;
            in_pass   = 1'b1;
            fetch_or_finish(r);
            emit = 1'b1;
          end
          default: ;
        endcase
        cmd_held = '0;
      end
    end
    if (emit) loader_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input loader_result_t got,
                                 input loader_result_t want);
    string got_s;
    string want_s;
    mismatches++;
    got_s  = $sformatf("kind %0d reply %h addr %h sum %h dest %h pc %h",
                       got.kind, got.reply, got.addr, got.sum, got.dest, got.pc);
    want_s = $sformatf("kind %0d reply %h addr %h sum %h dest %h pc %h",
                       want.kind, want.reply, want.addr, want.sum, want.dest,
                       want.pc);
    $display("%0t ns: %s: got %s / want %s", $time, what, got_s, want_s);
  endtask

  always @(posedge clk) begin
    loader_result_t got;
    loader_result_t want;
    got = {out_result_kind, out_reply_mail, out_read_address,
           out_checksum, out_dest_address, out_start_pc};
    if (!rst_n) begin
      cmd_held  = '0;
      src_base  = '0;
      load_len  = '0;
      dest_word = '0;
      entry_pc  = '0;
      rot_sum   = '0;
      fetch_idx = '0;
      in_pass   = 1'b0;
      loader_results.delete();
    end else begin
      if (in_valid && !in_stall)
        loader_step(in_operation, in_mail_word, in_memory_byte);
      if (out_valid && !out_stall) begin
        if (loader_results.size() == 0) begin
          report_mismatch("result with none due", got, '0);
        end else begin
          want = loader_results.pop_front();
          if (got.kind !== want.kind)        report_mismatch("result_kind", got, want);
          else if (got.reply !== want.reply) report_mismatch("reply_mail", got, want);
          else if (got.addr !== want.addr)   report_mismatch("read_address", got, want);
          else if (got.sum !== want.sum)     report_mismatch("checksum", got, want);
          else if (got.dest !== want.dest)   report_mismatch("dest_address", got, want);
          else if (got.pc !== want.pc)       report_mismatch("start_pc", got, want);
        end
      end
    end
    open_results <= loader_results.size();
    fail_count   <= mismatches;
  end

endmodule

// ===== bench/tb_mailbox_boot_loader_with_checksum_unit.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for mailbox_boot_loader_with_checksum_unit: boot command
// sequences, noise mails and bytes, random stalls. Depends on mbl_pkg and mbl_result_checker.
module tb_mailbox_boot_loader_with_checksum_unit;
  import mbl_pkg::*;

  localparam logic OP_MAIL = 1'b0;
  localparam logic OP_BYTE = 1'b1;
  localparam logic [WORD_W-1:0] CMD_UNKNOWN = 32'h80F3_B002;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_operation = 1'b0;
  logic [WORD_W-1:0] in_mail_word = '0;
  logic [BYTE_W-1:0] in_memory_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KIND_W-1:0] out_result_kind;
  logic [WORD_W-1:0] out_reply_mail;
  logic [WORD_W-1:0] out_read_address;
  logic [WORD_W-1:0] out_checksum;
  logic [WORD_W-1:0] out_dest_address;
  logic [WORD_W-1:0] out_start_pc;

  int open_results;
  int fail_count;

  int          send_pct = 0;
  int          recv_pct = 0;
  int          hold_count = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          items_done = 0;
  int unsigned cur_len = 0;

  mailbox_boot_loader_with_checksum_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_mail_word     (in_mail_word),
    .in_memory_byte   (in_memory_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_reply_mail   (out_reply_mail),
    .out_read_address (out_read_address),
    .out_checksum     (out_checksum),
    .out_dest_address (out_dest_address),
    .out_start_pc     (out_start_pc)
  );

  mbl_result_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_mail_word     (in_mail_word),
    .in_memory_byte   (in_memory_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_reply_mail   (out_reply_mail),
    .out_read_address (out_read_address),
    .out_checksum     (out_checksum),
    .out_dest_address (out_dest_address),
    .out_start_pc     (out_start_pc),
    .open_results     (open_results),
    .fail_count       (fail_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_seen != hold_count) begin
      hold_seen = hold_count;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // Offer one transaction after a random gap; return at the edge that takes it.
  task automatic put_item(input logic op, input logic [WORD_W-1:0] mail,
                          input logic [BYTE_W-1:0] mem_byte, input bit live);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_mail_word   <= mail;
    in_memory_byte <= mem_byte;
    do @(posedge clk); while (in_stall);
    if (live) items_done++;
  endtask

  // Payload fields the operation does not use carry random junk.
  task automatic send_mail(input logic [WORD_W-1:0] w, input bit live);
    put_item(OP_MAIL, w, BYTE_W'($urandom()), live);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit live);
    put_item(OP_BYTE, $urandom(), b, live);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
  endtask

  task automatic boot_sequence();
    logic [WORD_W-1:0] w;
    if ($urandom_range(99) < 70) begin
      w = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(15) : $urandom();
      send_mail(CMD_SOURCE, 1);
      send_mail(w, 1);
    end
    if ($urandom_range(99) < 80) begin
      cur_len = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(8);
      send_mail(CMD_LENGTH, 1);
      send_mail(cur_len, 1);
    end
    if ($urandom_range(99) < 60) begin
      send_mail(CMD_DEST, 1);
      send_mail($urandom(), 1);
    end
    // broken order: a command word lands as the parameter of another
    if ($urandom_range(99) < 10) begin
      send_mail(($urandom_range(1) == 0) ? CMD_DEST : CMD_SOURCE, 1);
      send_mail(($urandom_range(1) == 0) ? CMD_BOOT : CMD_LENGTH, 1);
    end
    send_mail(CMD_BOOT, 1);
    send_mail($urandom(), 1);
    for (int unsigned i = 0; i < cur_len; i++) begin
      if ($urandom_range(99) < 4) send_mail($urandom(), 0);
      send_byte(BYTE_W'($urandom()), 1);
    end
    if ($urandom_range(99) < 5) send_byte(BYTE_W'($urandom()), 0);
  endtask

  task automatic noise_item();
    logic [WORD_W-1:0] w;
    case ($urandom_range(3))
      0: send_byte(BYTE_W'($urandom()), 0);
      1: begin
        send_mail({CMD_MAGIC, 16'($urandom())}, 1);
        send_mail($urandom(), 1);
      end
      default: begin
        w = $urandom();
        if ($urandom_range(4) == 0) w[31:16] = CMD_MAGIC ^ (16'h1 << $urandom_range(15));
        if (w[31:16] == CMD_MAGIC) w[16] = ~w[16];
        send_mail(w, 1);
      end
    endcase
  endtask

  task automatic random_phase(input int upto, input bit with_hold);
    bit held;
    held = 1'b0;
    while (items_done < upto) begin
      if ($urandom_range(3) == 0) noise_item();
      else boot_sequence();
      if (with_hold && !held && items_done > upto - 250) begin
        hold_count <= hold_count + 1;
        held = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n    <= 1'b1;
    send_pct = 18;
    recv_pct <= 57;

    send_mail(32'h0000_0000, 1);
    send_mail(32'hFFFF_FFFF, 1);
    send_byte(8'hA5, 0);                 // no pass running: dropped
    send_mail(CMD_SOURCE, 1);
    send_mail(32'hFFFF_FFFE, 1);         // read addresses wrap past the top
    send_mail(CMD_LENGTH, 1);
    send_mail(32'd4, 1);
    send_mail(CMD_DEST, 1);
    send_mail(32'h1234_5678, 1);
    send_mail(CMD_UNKNOWN, 1);
    send_mail(32'hDEAD_BEEF, 1);
    send_mail(CMD_BOOT, 1);
    send_mail(32'h0000_0100, 1);
    send_byte(8'h00, 1);
    send_mail(CMD_SOURCE, 0);            // mail inside a pass: dropped
    send_byte(8'hFF, 1);
    send_byte(8'h5A, 1);
    send_byte(8'hC3, 1);
    send_mail(CMD_LENGTH, 1);
    send_mail(32'd0, 1);
    send_mail(CMD_BOOT, 1);              // zero length: done right away
    send_mail(32'hFFFF_FFFF, 1);
    send_mail({CMD_MAGIC, 16'h0000}, 1);
    send_mail(CMD_BOOT, 1);
    send_mail(32'h80F2_FFFF, 1);
    cur_len = 0;

    random_phase(500, 1);
    drain();
    send_pct = 57;
    recv_pct <= 18;
    random_phase(1000, 0);
    drain();
    send_pct = 0;
    recv_pct <= 0;
    random_phase(1500, 0);

    // full-scale length: the pass stays open past the end of the run
    send_mail(CMD_LENGTH, 1);
    send_mail(32'hFFFF_FFFF, 1);
    send_mail(CMD_BOOT, 1);
    send_mail($urandom(), 1);
    repeat (5) send_byte(BYTE_W'($urandom()), 1);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule
